/* design/taa_pkg.sv */
// Shared types and constants for the triangle area accumulator.
package taa_pkg;

    localparam int AREA_BITS = 42;
    localparam int SUM_BITS  = 60;
    localparam int STEP_BITS = 4;

    // Multiplier sequence: six cross-product terms, then three partial squares per axis.
    localparam logic [STEP_BITS-1:0] STEP_CROSS_LAST = 4'd5;
    localparam logic [STEP_BITS-1:0] STEP_LAST       = 4'd14;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DRAIN,
        S_START,
        S_ROOT,
        S_SUM
    } t_state;

    typedef struct packed {
        logic                 vld;
        logic [STEP_BITS-1:0] step;
    } t_mul_tag;

endpackage

/* design/taa_mul.sv */
// Shared signed multiplier with a registered product and step tag.
module taa_mul #(
    parameter int OW = 22
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  taa_pkg::t_mul_tag    i_tag,
    input  logic signed [OW-1:0] i_a,
    input  logic signed [OW-1:0] i_b,
    output taa_pkg::t_mul_tag    o_tag,
    output logic signed [2*OW-1:0] o_prod
);
    import taa_pkg::*;

    t_mul_tag              r_tag;
    logic signed [2*OW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_tag  = r_tag;
    assign o_prod = r_prod;
endmodule

/* design/taa_sqrt.sv */
// Bit-serial floor square root, two radicand bits per cycle.
module taa_sqrt #(
    parameter int RW = 43
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2*RW-1:0] i_radicand,
    output logic            o_done,
    output logic [RW-1:0]   o_root
);
    import taa_pkg::*;

    localparam int RMW = RW + 3;
    localparam int CW  = $clog2(RW + 1);

    logic [2*RW-1:0] r_n;
    logic [RMW-1:0]  r_rem;
    logic [RW-1:0]   r_root;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [RMW-1:0] n_shift;
    logic [RMW-1:0] n_trial;
    logic           n_fit;

    always_comb begin
        n_shift = {r_rem[RMW-3:0], r_n[2*RW-1 -: 2]};
        n_trial = {r_root, 2'b01};
        n_fit   = n_shift >= n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n    <= {r_n[2*RW-3:0], 2'b00};
            r_rem  <= n_fit ? (n_shift - n_trial) : n_shift;
            r_root <= {r_root[RW-2:0], n_fit};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

/* design/triangle_area_accumulator_top.sv */
// Top level of the triangle area accumulator: sequencer, accumulators and stream ports.
//
//  channel   | dir | tdata (low bit up)                          | tuser
//  ----------+-----+---------------------------------------------+----------------
//  s_axis    | in  | a_x a_y a_z b_x b_y b_z c_x c_y c_z, zero pad| first_triangle
//  m_axis    | out | tri_area[41:0] area_sum[59:0], zero pad      | saturated
//
// One triangle passes through the idle state that accepts it, multiplier issue
// of six cross-product terms and nine partial squares, a drain, a root start,
// the bit-serial root steps with their done flag, and the sum state, which
// waits while an earlier result is still held on m_axis.
// The bit-serial square root over the squared cross length takes most of that time.
// s_axis_tready is high only while the sequencer is idle; a result waiting on
// m_axis holds the next result back but not the next input item.
// Reset clears the running sum, the sticky saturation flag and all control.
module triangle_area_accumulator_top #(
    parameter int COORD_BITS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, then zero pad
    input  logic [((9*COORD_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    // first_triangle
    input  logic                                  i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // tri_area, area_sum, then zero pad
    output logic [((taa_pkg::AREA_BITS+taa_pkg::SUM_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // saturated
    output logic                                  o_m_axis_tuser
);
    import taa_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;          // edge vector component
    localparam int WW   = 2*CB + 3;        // cross product component, signed
    localparam int MAGW = 2*CB + 2;        // its magnitude
    localparam int HW   = MAGW / 2;        // magnitude half for split squaring
    localparam int OW   = CB + 2;          // multiplier operand
    localparam int PW   = 2*OW;
    localparam int RW   = MAGW + 1;        // root width
    localparam int SQW  = 2*RW;            // squared length
    localparam int XW   = (RW > AREA_BITS) ? RW : AREA_BITS;
    localparam int OTW  = ((AREA_BITS+SUM_BITS+7)/8)*8;

    // Control and state
    t_state                r_state, n_state;
    logic [STEP_BITS-1:0]  r_step;
    logic                  r_first;
    logic signed [DW-1:0]  r_u [3];
    logic signed [DW-1:0]  r_v [3];
    logic signed [WW-1:0]  r_acc;
    logic signed [WW-1:0]  r_w [3];
    logic [SQW-1:0]        r_len2;
    logic [SUM_BITS-1:0]   r_sum;
    logic                  r_sat;
    logic                  r_out_valid;
    logic [AREA_BITS-1:0]  r_out_area;

    logic                  in_acc;
    t_mul_tag              mul_in_tag, mul_out_tag;
    logic signed [OW-1:0]  mul_a, mul_b;
    logic signed [PW-1:0]  mul_prod;
    logic                  root_start, root_done;
    logic [RW-1:0]         root;

    logic [1:0]            sq_comp;
    logic [1:0]            sq_kind;
    logic [1:0]            pq_kind;
    logic [MAGW-1:0]       mag;
    logic [SQW-1:0]        sq_term;
    logic [AREA_BITS-1:0]  area;
    logic [SUM_BITS:0]     n_sum_wide;
    logic                  n_ovf;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // Latch edge vectors on accept
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int k = 0; k < 3; k++) begin
                r_u[k] <= DW'(signed'(i_s_axis_tdata[(3+k)*CB +: CB]))
                        - DW'(signed'(i_s_axis_tdata[k*CB +: CB]));
                r_v[k] <= DW'(signed'(i_s_axis_tdata[(6+k)*CB +: CB]))
                        - DW'(signed'(i_s_axis_tdata[k*CB +: CB]));
            end
            r_first <= i_s_axis_tuser;
        end
    end

    // Which axis and which partial square a step covers
    always_comb begin
        case (r_step) inside
            4'd6, 4'd7, 4'd8:    sq_comp = 2'd0;
            4'd9, 4'd10, 4'd11:  sq_comp = 2'd1;
            default:             sq_comp = 2'd2;
        endcase
        case (r_step) inside
            4'd6, 4'd9, 4'd12:   sq_kind = 2'd0;
            4'd7, 4'd10, 4'd13:  sq_kind = 2'd1;
            default:             sq_kind = 2'd2;
        endcase
        case (mul_out_tag.step) inside
            4'd6, 4'd9, 4'd12:   pq_kind = 2'd0;
            4'd7, 4'd10, 4'd13:  pq_kind = 2'd1;
            default:             pq_kind = 2'd2;
        endcase
    end

    // Operand select for the shared multiplier
    always_comb begin
        mag = r_w[sq_comp][WW-1] ? MAGW'(-r_w[sq_comp]) : MAGW'(r_w[sq_comp]);
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            4'd0:    begin mul_a = OW'(r_u[1]); mul_b = OW'(r_v[2]); end
            4'd1:    begin mul_a = OW'(r_u[2]); mul_b = OW'(r_v[1]); end
            4'd2:    begin mul_a = OW'(r_u[2]); mul_b = OW'(r_v[0]); end
            4'd3:    begin mul_a = OW'(r_u[0]); mul_b = OW'(r_v[2]); end
            4'd4:    begin mul_a = OW'(r_u[0]); mul_b = OW'(r_v[1]); end
            4'd5:    begin mul_a = OW'(r_u[1]); mul_b = OW'(r_v[0]); end
            default: begin
                case (sq_kind)
                    2'd0:    begin mul_a = {1'b0, mag[HW-1:0]};    mul_b = {1'b0, mag[HW-1:0]};    end
                    2'd1:    begin mul_a = {1'b0, mag[MAGW-1:HW]}; mul_b = {1'b0, mag[HW-1:0]};    end
                    default: begin mul_a = {1'b0, mag[MAGW-1:HW]}; mul_b = {1'b0, mag[MAGW-1:HW]}; end
                endcase
            end
        endcase
        mul_in_tag.vld  = (r_state == S_MUL);
        mul_in_tag.step = r_step;
    end

    taa_mul #(.OW(OW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (mul_in_tag),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_tag   (mul_out_tag),
        .o_prod  (mul_prod)
    );

    // Place a partial square at its weight
    always_comb begin
        sq_term = {{(SQW-PW+1){1'b0}}, mul_prod[PW-2:0]};
        case (pq_kind)
            2'd0:    sq_term = sq_term;
            2'd1:    sq_term = sq_term << (HW + 1);
            default: sq_term = sq_term << (2*HW);
        endcase
    end

    // Fold products into cross components, then into the squared length
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_len2 <= '0;
        end else if (mul_out_tag.vld) begin
            if (mul_out_tag.step <= STEP_CROSS_LAST) begin
                if (!mul_out_tag.step[0]) begin
                    r_acc <= mul_prod[WW-1:0];
                end else begin
                    r_w[mul_out_tag.step[2:1]] <= r_acc - mul_prod[WW-1:0];
                end
            end else begin
                r_len2 <= r_len2 + sq_term;
            end
        end
    end

    assign root_start = (r_state == S_START);

    taa_sqrt #(.RW(RW)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (r_len2),
        .o_done     (root_done),
        .o_root     (root)
    );

    // Clamp area and add into the saturating sum
    always_comb begin
        if (XW'(root) > XW'({AREA_BITS{1'b1}})) begin
            area = {AREA_BITS{1'b1}};
        end else begin
            area = AREA_BITS'(root);
        end
        n_sum_wide = (r_first ? '0 : {1'b0, r_sum}) + (SUM_BITS+1)'(area);
        n_ovf      = n_sum_wide[SUM_BITS];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MUL) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_MUL;
            S_MUL:   if (r_step == STEP_LAST) n_state = S_DRAIN;
            S_DRAIN: n_state = S_START;
            S_START: n_state = S_ROOT;
            S_ROOT:  if (root_done) n_state = S_SUM;
            S_SUM:   if (!r_out_valid || i_m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Running sum and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_SUM && (!r_out_valid || i_m_axis_tready)) begin
                r_sum       <= n_ovf ? {SUM_BITS{1'b1}} : n_sum_wide[SUM_BITS-1:0];
                r_sat       <= (r_first ? 1'b0 : r_sat) | n_ovf;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM && (!r_out_valid || i_m_axis_tready)) begin
            r_out_area <= area;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OTW'({r_sum, r_out_area});
    assign o_m_axis_tuser  = r_sat;
endmodule

/* design/taa_checker.sv */
// Port-level checks for the triangle area accumulator, bound to the top level.
module taa_checker #(
    parameter int COORD_BITS = 20
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_s_axis_tvalid,
    input logic                                  o_s_axis_tready,
    input logic [((9*COORD_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    input logic                                  i_s_axis_tuser,
    input logic                                  o_m_axis_tvalid,
    input logic                                  i_m_axis_tready,
    input logic [((taa_pkg::AREA_BITS+taa_pkg::SUM_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    input logic                                  o_m_axis_tuser
);
    import taa_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)
        && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // Busy after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ready right after accept");

    // Saturated flag means the sum sits at its maximum
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
        o_m_axis_tdata[AREA_BITS+SUM_BITS-1:AREA_BITS] == {SUM_BITS{1'b1}})
        else $error("saturated without full sum");

    // No result straight out of reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");
endmodule

bind triangle_area_accumulator_top taa_checker #(.COORD_BITS(COORD_BITS)) u_taa_checker (.*);
